@@ rtl/mrs_pkg.sv @@
// mrs_pkg: types and constants for the modbus rtu slave engine
// shared by mrs_crc and modbus_rtu_slave_engine; no dependencies
package mrs_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0]  ExcFlag = 8'h80;
  localparam logic [15:0] CrcLsb  = 16'h0001;

  localparam logic [1:0] CfgSlaveAddress = 2'd0;
  localparam logic [1:0] CfgGapTicks     = 2'd1;
  localparam logic [1:0] CfgCoilValues   = 2'd2;

  localparam logic [7:0] FcReadCoils     = 8'd1;
  localparam logic [7:0] FcReadInputs    = 8'd2;
  localparam logic [7:0] FcReadHolding   = 8'd3;
  localparam logic [7:0] FcReadInRegs    = 8'd4;
  localparam logic [7:0] FcWriteCoil     = 8'd5;
  localparam logic [7:0] FcWriteSingle   = 8'd6;
  localparam logic [7:0] FcWriteCoils    = 8'd15;
  localparam logic [7:0] FcWriteMultiple = 8'd16;

  localparam logic [1:0] ExcIllegalFunc = 2'd1;
  localparam logic [1:0] ExcIllegalAddr = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_CHK, ST_EVAL, ST_W1, ST_W2, ST_W3,
    ST_PREP, ST_GEN, ST_CRCW, ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    RESP_EXC, RESP_COIL, RESP_READ, RESP_ECHO, RESP_WMUL
  } resp_e;

  typedef struct packed {
    logic       init;
    logic       start;
    logic [7:0] data;
  } crc_ctrl_t;

endpackage

@@ rtl/mrs_ram.sv @@
// mrs_ram: generic single write, single read ram with registered read
// no dependencies
module mrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/mrs_crc.sv @@
// mrs_crc: bit-serial crc-16 unit, one bit per cycle
// depends on mrs_pkg
module mrs_crc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mrs_pkg::crc_ctrl_t ctrl_i,
  output logic               busy_o,
  output logic [15:0]        crc_o
);

  logic [15:0] crc_q, crc_d;
  logic [3:0]  cnt_q, cnt_d;

  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    if (ctrl_i.init) begin
      crc_d = mrs_pkg::CrcInit;
      cnt_d = 4'd0;
    end else if (ctrl_i.start) begin
      crc_d = crc_q ^ {8'd0, ctrl_i.data};
      cnt_d = 4'd8;
    end else if (cnt_q != 4'd0) begin
      if ((crc_q & mrs_pkg::CrcLsb) != 16'd0) begin
        crc_d = (crc_q >> 1) ^ mrs_pkg::CrcPoly;
      end else begin
        crc_d = crc_q >> 1;
      end
      cnt_d = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= mrs_pkg::CrcInit;
      cnt_q <= 4'd0;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
    end
  end

  assign busy_o = (cnt_q != 4'd0);
  assign crc_o  = crc_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> (cnt_q == 4'd0)) else $error("crc start while busy");
  a_count_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 4'd0 && !ctrl_i.init) |=> (cnt_q == $past(cnt_q) - 4'd1))
    else $error("crc count skipped");
  a_init_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.init |=> (crc_q == mrs_pkg::CrcInit)) else $error("crc init lost");

endmodule

@@ rtl/modbus_rtu_slave_engine.sv @@
// Modbus RTU slave engine: bytes and ticks in, response bytes out. A byte or a tick that
// does not end a frame is taken in ST_IDLE. A frame end (4+ bytes, no overflow) walks the
// stored frame via the bit-serial crc unit (ST_RD, ST_CHK per byte; received crc bytes
// skip it), then writes registers for function 16 (ST_W1-ST_W3 per register) and emits
// each response byte via ST_PREP, ST_GEN, ST_CRCW (crc unit: one bit per cycle), each crc
// byte via ST_PREP and ST_GEN, stalled by out_ready_i; no item is taken during that work.
module modbus_rtu_slave_engine #(
  parameter int unsigned REG_COUNT   = 16,
  parameter int unsigned FRAME_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  tx_byte_o,
  output logic        last_byte_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned AW   = $clog2(FRAME_DEPTH);
  localparam int unsigned LW   = $clog2(FRAME_DEPTH + 1);
  localparam int unsigned RA_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int unsigned RC_W = $clog2(REG_COUNT + 1);

  mrs_pkg::state_e state_q, state_d;
  mrs_pkg::resp_e  resp_q, resp_d;

  logic [7:0]  slave_addr_q;
  logic [15:0] gap_ticks_q, coil_values_q;
  logic [LW-1:0] len_q, len_d;
  logic          ovf_q, ovf_d;
  logic [15:0]   sil_q, sil_d;
  logic [LW-1:0] fidx_q, fidx_d;
  logic [7:0]    hdr_q [7];
  logic [7:0]    hdr_d [7];
  logic [7:0]    rxlo_q, rxlo_d, rxhi_q, rxhi_d;
  logic [8:0]    widx_q, widx_d;
  logic [RC_W-1:0] wcnt_q, wcnt_d;
  logic [7:0]    whi_q, whi_d;
  logic [6:0]    k_q, k_d, n_q, n_d;
  logic [1:0]    exc_q, exc_d;
  logic          out_valid_q, out_valid_d, last_q, last_d;
  logic [7:0]    tx_q, tx_d;
  logic [REG_COUNT-1:0] hr_vld_q, hr_vld_d;
  logic          hr_vld_rd_q, hr_vld_rd_d;

  logic          fr_we;
  logic [AW-1:0] fr_waddr, fr_raddr;
  logic [7:0]    fr_rdata;
  logic          hr_we;
  logic [RA_W-1:0] hr_waddr, hr_raddr;
  logic [15:0]   hr_wdata, hr_rdata;

  mrs_pkg::crc_ctrl_t crc_ctrl;
  logic          crc_busy;
  logic [15:0]   crc_val;

  logic [15:0] start_w, qty_w;
  logic [16:0] span_w;
  logic [6:0]  ci_w;
  logic [7:0]  shamt_w, rem_w, cmask_w, coil_byte_w, resp_byte_w;
  logic [31:0] coil_sh_w;
  logic [6:0]  rdi_w;
  logic [15:0] hr_rd_w;
  logic [8:0]  len9_w;

  mrs_ram #(.Width(8), .Depth(FRAME_DEPTH)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (rx_byte_i),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  mrs_ram #(.Width(16), .Depth(REG_COUNT)) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (hr_we),
    .waddr_i (hr_waddr),
    .wdata_i (hr_wdata),
    .raddr_i (hr_raddr),
    .rdata_o (hr_rdata)
  );

  mrs_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .busy_o (crc_busy),
    .crc_o  (crc_val)
  );

  assign start_w = {hdr_q[2], hdr_q[3]};
  assign qty_w   = {hdr_q[4], hdr_q[5]};
  assign span_w  = {1'b0, start_w} + {1'b0, qty_w};
  assign len9_w  = 9'(len_q);

  // coil byte for response index k
  assign ci_w        = k_q - 7'd3;
  assign shamt_w     = 8'(start_w[6:0]) + {ci_w[4:0], 3'b000};
  assign coil_sh_w   = {16'd0, coil_values_q} >> shamt_w;
  assign rem_w       = qty_w[7:0] - {ci_w[4:0], 3'b000};
  assign cmask_w     = (rem_w >= 8'd8) ? 8'hFF : 8'((9'd1 << rem_w[3:0]) - 9'd1);
  assign coil_byte_w = coil_sh_w[7:0] & cmask_w;
  assign hr_rd_w     = hr_vld_rd_q ? hr_rdata : 16'd0;

  always_comb begin
    resp_byte_w = 8'd0;
    case (resp_q)
      mrs_pkg::RESP_EXC: begin
        case (k_q)
          7'd0:    resp_byte_w = slave_addr_q;
          7'd1:    resp_byte_w = hdr_q[1] | mrs_pkg::ExcFlag;
          default: resp_byte_w = 8'(exc_q);
        endcase
      end
      mrs_pkg::RESP_COIL: begin
        case (k_q)
          7'd0:    resp_byte_w = slave_addr_q;
          7'd1:    resp_byte_w = mrs_pkg::FcReadCoils;
          7'd2:    resp_byte_w = 8'(n_q - 7'd3);
          default: resp_byte_w = coil_byte_w;
        endcase
      end
      mrs_pkg::RESP_READ: begin
        case (k_q)
          7'd0:    resp_byte_w = slave_addr_q;
          7'd1:    resp_byte_w = mrs_pkg::FcReadHolding;
          7'd2:    resp_byte_w = {qty_w[6:0], 1'b0};
          default: resp_byte_w = ci_w[0] ? hr_rd_w[7:0] : hr_rd_w[15:8];
        endcase
      end
      mrs_pkg::RESP_ECHO: begin
        resp_byte_w = (k_q < 7'd6) ? hdr_q[k_q[2:0]] : 8'd0;
      end
      mrs_pkg::RESP_WMUL: begin
        case (k_q)
          7'd0:    resp_byte_w = slave_addr_q;
          7'd1:    resp_byte_w = mrs_pkg::FcWriteMultiple;
          7'd2:    resp_byte_w = hdr_q[2];
          7'd3:    resp_byte_w = hdr_q[3];
          7'd4:    resp_byte_w = hdr_q[4];
          default: resp_byte_w = hdr_q[5];
        endcase
      end
      default: resp_byte_w = 8'd0;
    endcase
  end

  always_comb begin
    rdi_w       = (k_q - 7'd3) >> 1;
    state_d     = state_q;
    resp_d      = resp_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    sil_d       = sil_q;
    fidx_d      = fidx_q;
    hdr_d       = hdr_q;
    rxlo_d      = rxlo_q;
    rxhi_d      = rxhi_q;
    widx_d      = widx_q;
    wcnt_d      = wcnt_q;
    whi_d       = whi_q;
    k_d         = k_q;
    n_d         = n_q;
    exc_d       = exc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    last_d      = last_q;
    tx_d        = tx_q;
    hr_vld_d    = hr_vld_q;
    hr_vld_rd_d = hr_vld_rd_q;
    fr_we       = 1'b0;
    fr_waddr    = len_q[AW-1:0];
    fr_raddr    = fidx_q[AW-1:0];
    hr_we       = 1'b0;
    hr_waddr    = RA_W'(start_w);
    hr_wdata    = qty_w;
    hr_raddr    = RA_W'(start_w + 16'(rdi_w));
    crc_ctrl    = '0;
    in_ready_o  = 1'b0;

    case (state_q)
      mrs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!cmd_i) begin
            if (len_q < LW'(FRAME_DEPTH)) begin
              fr_we = 1'b1;
              len_d = len_q + LW'(1);
            end else begin
              ovf_d = 1'b1;
            end
            sil_d = 16'd0;
          end else if (len_q != '0) begin
            if (sil_q < gap_ticks_q) begin
              sil_d = sil_q + 16'd1;
            end else if (ovf_q || len_q < LW'(4)) begin
              state_d = mrs_pkg::ST_DONE;
            end else begin
              crc_ctrl.init = 1'b1;
              fidx_d        = '0;
              for (int i = 0; i < 7; i++) begin
                hdr_d[i] = 8'd0;
              end
              state_d = mrs_pkg::ST_RD;
            end
          end
        end
      end
      mrs_pkg::ST_RD: begin
        if (!crc_busy) begin
          state_d = mrs_pkg::ST_CHK;
        end
      end
      mrs_pkg::ST_CHK: begin
        if (fidx_q < LW'(7)) begin
          hdr_d[fidx_q[2:0]] = fr_rdata;
        end
        if (fidx_q == len_q - LW'(2)) begin
          rxlo_d = fr_rdata;
        end
        if (fidx_q == len_q - LW'(1)) begin
          rxhi_d = fr_rdata;
        end
        if (fidx_q < len_q - LW'(2)) begin
          crc_ctrl.start = 1'b1;
          crc_ctrl.data  = fr_rdata;
        end
        fidx_d  = fidx_q + LW'(1);
        state_d = (fidx_q + LW'(1) == len_q) ? mrs_pkg::ST_EVAL : mrs_pkg::ST_RD;
      end
      mrs_pkg::ST_EVAL: begin
        if (!crc_busy) begin
          state_d = mrs_pkg::ST_DONE;
          if ((hdr_q[0] == slave_addr_q || hdr_q[0] == 8'd0) &&
              crc_val == {rxhi_q, rxlo_q}) begin
            k_d   = 7'd0;
            exc_d = mrs_pkg::ExcIllegalAddr;
            case (hdr_q[1])
              mrs_pkg::FcReadCoils: begin
                if (span_w > 17'(REG_COUNT)) begin
                  resp_d = mrs_pkg::RESP_EXC;
                  n_d    = 7'd3;
                end else begin
                  resp_d = mrs_pkg::RESP_COIL;
                  n_d    = 7'd3 + 7'((qty_w[5:0] + 6'd7) >> 3);
                end
                crc_ctrl.init = 1'b1;
                state_d       = mrs_pkg::ST_PREP;
              end
              mrs_pkg::FcReadHolding: begin
                if (span_w > 17'(REG_COUNT)) begin
                  resp_d = mrs_pkg::RESP_EXC;
                  n_d    = 7'd3;
                end else begin
                  resp_d = mrs_pkg::RESP_READ;
                  n_d    = 7'd3 + {qty_w[5:0], 1'b0};
                end
                crc_ctrl.init = 1'b1;
                state_d       = mrs_pkg::ST_PREP;
              end
              mrs_pkg::FcWriteSingle: begin
                if (start_w >= 16'(REG_COUNT)) begin
                  resp_d = mrs_pkg::RESP_EXC;
                  n_d    = 7'd3;
                end else begin
                  hr_we    = 1'b1;
                  hr_vld_d[RA_W'(start_w)] = 1'b1;
                  resp_d   = mrs_pkg::RESP_ECHO;
                  n_d      = 7'd6;
                end
                crc_ctrl.init = 1'b1;
                state_d       = mrs_pkg::ST_PREP;
              end
              mrs_pkg::FcWriteMultiple: begin
                crc_ctrl.init = 1'b1;
                if (span_w > 17'(REG_COUNT) || 17'(hdr_q[6]) != {qty_w, 1'b0}) begin
                  resp_d  = mrs_pkg::RESP_EXC;
                  n_d     = 7'd3;
                  state_d = mrs_pkg::ST_PREP;
                end else begin
                  resp_d  = mrs_pkg::RESP_WMUL;
                  n_d     = 7'd6;
                  widx_d  = 9'd7;
                  wcnt_d  = '0;
                  state_d = (qty_w == 16'd0) ? mrs_pkg::ST_PREP : mrs_pkg::ST_W1;
                end
              end
              mrs_pkg::FcReadInputs, mrs_pkg::FcReadInRegs,
              mrs_pkg::FcWriteCoil, mrs_pkg::FcWriteCoils: begin
                state_d = mrs_pkg::ST_DONE;
              end
              default: begin
                resp_d        = mrs_pkg::RESP_EXC;
                n_d           = 7'd3;
                exc_d         = mrs_pkg::ExcIllegalFunc;
                crc_ctrl.init = 1'b1;
                state_d       = mrs_pkg::ST_PREP;
              end
            endcase
          end
        end
      end
      mrs_pkg::ST_W1: begin
        fr_raddr = widx_q[AW-1:0];
        state_d  = mrs_pkg::ST_W2;
      end
      mrs_pkg::ST_W2: begin
        whi_d    = (widx_q < len9_w) ? fr_rdata : 8'd0;
        fr_raddr = AW'(widx_q + 9'd1);
        state_d  = mrs_pkg::ST_W3;
      end
      mrs_pkg::ST_W3: begin
        hr_we    = 1'b1;
        hr_waddr = RA_W'(start_w + 16'(wcnt_q));
        hr_wdata = {whi_q, (widx_q + 9'd1 < len9_w) ? fr_rdata : 8'd0};
        hr_vld_d[RA_W'(start_w + 16'(wcnt_q))] = 1'b1;
        wcnt_d   = wcnt_q + RC_W'(1);
        widx_d   = widx_q + 9'd2;
        state_d  = (16'(wcnt_q) + 16'd1 == qty_w) ? mrs_pkg::ST_PREP : mrs_pkg::ST_W1;
      end
      mrs_pkg::ST_PREP: begin
        hr_vld_rd_d = hr_vld_q[RA_W'(start_w + 16'(rdi_w))];
        state_d     = mrs_pkg::ST_GEN;
      end
      mrs_pkg::ST_GEN: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          last_d      = 1'b0;
          if (k_q < n_q) begin
            tx_d           = resp_byte_w;
            crc_ctrl.start = 1'b1;
            crc_ctrl.data  = resp_byte_w;
            state_d        = mrs_pkg::ST_CRCW;
          end else if (k_q == n_q) begin
            tx_d    = crc_val[7:0];
            k_d     = k_q + 7'd1;
            state_d = mrs_pkg::ST_PREP;
          end else begin
            tx_d    = crc_val[15:8];
            last_d  = 1'b1;
            state_d = mrs_pkg::ST_DONE;
          end
        end
      end
      mrs_pkg::ST_CRCW: begin
        if (!crc_busy) begin
          k_d     = k_q + 7'd1;
          state_d = mrs_pkg::ST_PREP;
        end
      end
      mrs_pkg::ST_DONE: begin
        len_d   = '0;
        ovf_d   = 1'b0;
        sil_d   = 16'd0;
        state_d = mrs_pkg::ST_IDLE;
      end
      default: state_d = mrs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= mrs_pkg::ST_IDLE;
      slave_addr_q  <= 8'd1;
      gap_ticks_q   <= 16'd4000;
      coil_values_q <= 16'd0;
      len_q         <= '0;
      ovf_q         <= 1'b0;
      sil_q         <= 16'd0;
      out_valid_q   <= 1'b0;
      hr_vld_q      <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      sil_q       <= sil_d;
      out_valid_q <= out_valid_d;
      hr_vld_q    <= hr_vld_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          mrs_pkg::CfgSlaveAddress: slave_addr_q  <= cfg_data_i[7:0];
          mrs_pkg::CfgGapTicks:     gap_ticks_q   <= cfg_data_i;
          mrs_pkg::CfgCoilValues:   coil_values_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    resp_q      <= resp_d;
    fidx_q      <= fidx_d;
    hdr_q       <= hdr_d;
    rxlo_q      <= rxlo_d;
    rxhi_q      <= rxhi_d;
    widx_q      <= widx_d;
    wcnt_q      <= wcnt_d;
    whi_q       <= whi_d;
    k_q         <= k_d;
    n_q         <= n_d;
    exc_q       <= exc_d;
    last_q      <= last_d;
    tx_q        <= tx_d;
    hr_vld_rd_q <= hr_vld_rd_d;
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_q;
  assign last_byte_o = last_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(FRAME_DEPTH)) else $error("frame length past depth");
  a_ready_crc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !crc_busy) else $error("request taken with crc running");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mrs_pkg::ST_GEN && state_d == mrs_pkg::ST_DONE) |=> last_q)
    else $error("response closed without last byte");

endmodule
